// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro expands to one labeled concurrent assertion on a clock and active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// cond must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

// ===== rtl/tecf_pkg.sv =====
// Shared types and constants of the threshold edge crossing finder.
// No dependencies; used by the controller, datapath, top level and checker.
package tecf_pkg;

	localparam int PIX_W     = 8;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;
	localparam int ROW_W     = 10;
	localparam int TOTAL_W   = 22;
	localparam int ROW_LIMIT = 1024;

	localparam logic [CFG_W-1:0]   WIDTH_RESET     = 11'd1024;
	localparam logic [CFG_W-1:0]   HEIGHT_RESET    = 11'd1024;
	localparam logic [PIX_W-1:0]   THRESHOLD_RESET = 8'd127;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX       = {TOTAL_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH  = 2'd0,
		CFG_IMAGE_HEIGHT = 2'd1,
		CFG_THRESHOLD    = 2'd2
	} cfg_index_t;

	// which pixel a result describes, relative to the current input
	typedef enum logic [1:0] {
		KIND_UP    = 2'd0,  // pixel above, one row late
		KIND_LEFT  = 2'd1,  // left neighbor in the last row
		KIND_FINAL = 2'd2   // current pixel, end of frame
	} result_kind_t;

	typedef struct packed {
		logic         accept;
		logic         rd_next;
		logic         cap_up;
		logic         start;
		logic         step;
		logic         load;
		result_kind_t kind;
		logic         run_last;
		logic         commit;
	} dp_cmd_t;

	typedef struct packed {
		logic has_up;
		logic has_left;
		logic has_final;
		logic slot_free;
	} dp_status_t;

endpackage

// ===== rtl/threshold_edge_crossing_finder_top.sv =====
// Each accepted pixel is divided by FRAC_BITS+1 step restoring dividers, two for the pixel above
// (right and down) plus one for the left pixel, and then gives 0 to 3 result loads into the output
// register, which an output stall holds; a new pixel is accepted only once the last one is done. Reset
// (arst_n low) clears the FSM, counters, total and output valid at once and loads width 1024,
// height 1024, threshold 127; the previous-row memory is not cleared.
module threshold_edge_crossing_finder_top import tecf_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int FRAC_BITS = 8,
	localparam int COL_W = $clog2(MAX_WIDTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PIX_W-1:0]     pixel_value,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [COL_W-1:0]     pixel_col,
	output logic [ROW_W-1:0]     pixel_row,
	output logic                 right_found,
	output logic [FRAC_BITS:0]   right_frac,
	output logic                 down_found,
	output logic [FRAC_BITS:0]   down_frac,
	output logic [TOTAL_W-1:0]   crossing_total,
	output logic                 run_last,
	output logic                 frame_done
);

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	tecf_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	tecf_datapath #(.MAX_WIDTH(MAX_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pixel_value    (pixel_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pixel_col      (pixel_col),
		.pixel_row      (pixel_row),
		.right_found    (right_found),
		.right_frac     (right_frac),
		.down_found     (down_found),
		.down_frac      (down_frac),
		.crossing_total (crossing_total),
		.run_last       (run_last),
		.frame_done     (frame_done)
	);

endmodule

// ===== rtl/tecf_div_lane.sv =====
// One crossing lane: sign/range check and a restoring divider, one quotient bit per step.
// Depends on tecf_pkg.
module tecf_div_lane import tecf_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  logic                 clk,
	input  logic                 start,
	input  logic                 step,
	input  logic                 exists,
	input  logic [PIX_W-1:0]     cur,
	input  logic [PIX_W-1:0]     nb,
	input  logic [PIX_W-1:0]     thr,
	output logic                 found,
	output logic [FRAC_BITS:0]   frac
);

	logic signed [PIX_W:0] num, den;
	logic [PIX_W-1:0]      anum, aden;
	logic                  ok;
	logic [PIX_W:0]        rem_q;
	logic [PIX_W-1:0]      den_q;
	logic [FRAC_BITS:0]    quo_q;
	logic                  found_q;
	logic                  ge;
	logic [PIX_W:0]        diff;

	always_comb begin
		num  = $signed({1'b0, thr}) - $signed({1'b0, cur});
		den  = $signed({1'b0, nb}) - $signed({1'b0, cur});
		anum = num[PIX_W] ? PIX_W'(-num) : num[PIX_W-1:0];
		aden = den[PIX_W] ? PIX_W'(-den) : den[PIX_W-1:0];
		// t in [0,1]: same sign (or zero numerator) and |num| <= |den|
		ok = exists && (den != '0) && ((num == '0) || (num[PIX_W] == den[PIX_W]))
			&& (anum <= aden);
	end

	assign ge   = rem_q >= {1'b0, den_q};
	assign diff = ge ? (rem_q - {1'b0, den_q}) : rem_q;

	always_ff @(posedge clk) begin
		if (start) begin
			found_q <= ok;
			rem_q   <= {1'b0, anum};
			den_q   <= aden;
			quo_q   <= '0;
		end else if (step) begin
			rem_q <= {diff[PIX_W-1:0], 1'b0};
			quo_q <= {quo_q[FRAC_BITS-1:0], ge};
		end
	end

	assign found = found_q;
	assign frac  = found_q ? quo_q : '0;

endmodule

// ===== rtl/tecf_datapath.sv =====
// Datapath: config registers, counters, previous-row memory, three crossing lanes,
// running total and the output register. Depends on tecf_pkg and tecf_div_lane.
module tecf_datapath import tecf_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int FRAC_BITS = 8,
	localparam int COL_W = $clog2(MAX_WIDTH)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dp_cmd_t                cmd,
	output dp_status_t             status,
	input  logic                   cfg_valid,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic [PIX_W-1:0]       pixel_value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [COL_W-1:0]       pixel_col,
	output logic [ROW_W-1:0]       pixel_row,
	output logic                   right_found,
	output logic [FRAC_BITS:0]     right_frac,
	output logic                   down_found,
	output logic [FRAC_BITS:0]     down_frac,
	output logic [TOTAL_W-1:0]     crossing_total,
	output logic                   run_last,
	output logic                   frame_done
);

	localparam int CMP_W = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;

	logic [CFG_W-1:0]   width_q, height_q;
	logic [PIX_W-1:0]   thr_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [PIX_W-1:0]   prior_q;
	logic [TOTAL_W-1:0] total_q;
	logic [PIX_W-1:0]   pix_q, up_q, rd_data_q;
	logic [PIX_W-1:0]   row_mem_q [MAX_WIDTH];

	logic [CMP_W-1:0]   w_ext, w_eff;
	logic [CFG_W-1:0]   h_eff;
	logic               last_col, last_row;
	logic [COL_W-1:0]   rd_addr;

	logic               r_found, d_found, l_found;
	logic [FRAC_BITS:0] r_frac, d_frac, l_frac;

	logic [COL_W-1:0]   ld_col;
	logic [ROW_W-1:0]   ld_row;
	logic               ld_rf, ld_df, ld_done;
	logic [FRAC_BITS:0] ld_rfr, ld_dfr;
	logic [1:0]         bump;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W-1:0] new_total;

	// configuration, ready is always high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			thr_q    <= THRESHOLD_RESET;
		end else if (cfg_valid) begin
			case (cfg_index_t'(cfg_index))
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				CFG_THRESHOLD:    thr_q    <= cfg_data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped image size; counters past the end count as on it
	always_comb begin
		w_ext = CMP_W'(width_q);
		if (width_q == '0)
			w_eff = CMP_W'(1);
		else if (w_ext > CMP_W'(MAX_WIDTH))
			w_eff = CMP_W'(MAX_WIDTH);
		else
			w_eff = w_ext;
		if (height_q == '0)
			h_eff = CFG_W'(1);
		else if (height_q > CFG_W'(ROW_LIMIT))
			h_eff = CFG_W'(ROW_LIMIT);
		else
			h_eff = height_q;
		last_col = (CMP_W'(col_q) + CMP_W'(1)) >= w_eff;
		last_row = (CFG_W'(row_q) + CFG_W'(1)) >= h_eff;
	end

	assign status.has_up    = row_q != '0;
	assign status.has_left  = last_row && (col_q != '0);
	assign status.has_final = last_row && last_col;
	assign status.slot_free = !out_valid || out_ready;

	assign rd_addr = (cmd.rd_next && !last_col) ? col_q + COL_W'(1) : col_q;

	always_ff @(posedge clk) begin
		rd_data_q <= row_mem_q[rd_addr];
		if (cmd.start)
			row_mem_q[col_q] <= pix_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept)
			pix_q <= pixel_value;
		if (cmd.cap_up)
			up_q <= rd_data_q;
	end

	tecf_div_lane #(.FRAC_BITS(FRAC_BITS)) u_right (
		.clk(clk), .start(cmd.start), .step(cmd.step), .exists(!last_col),
		.cur(up_q), .nb(last_col ? up_q : rd_data_q), .thr(thr_q),
		.found(r_found), .frac(r_frac)
	);

	tecf_div_lane #(.FRAC_BITS(FRAC_BITS)) u_down (
		.clk(clk), .start(cmd.start), .step(cmd.step), .exists(1'b1),
		.cur(up_q), .nb(pix_q), .thr(thr_q),
		.found(d_found), .frac(d_frac)
	);

	tecf_div_lane #(.FRAC_BITS(FRAC_BITS)) u_left (
		.clk(clk), .start(cmd.start), .step(cmd.step), .exists(1'b1),
		.cur(prior_q), .nb(pix_q), .thr(thr_q),
		.found(l_found), .frac(l_frac)
	);

	always_comb begin
		ld_col  = col_q;
		ld_row  = row_q;
		ld_rf   = 1'b0;
		ld_rfr  = '0;
		ld_df   = 1'b0;
		ld_dfr  = '0;
		ld_done = 1'b0;
		case (cmd.kind)
			KIND_UP: begin
				ld_row = row_q - ROW_W'(1);
				ld_rf  = r_found;
				ld_rfr = r_frac;
				ld_df  = d_found;
				ld_dfr = d_frac;
			end
			KIND_LEFT: begin
				ld_col = col_q - COL_W'(1);
				ld_rf  = l_found;
				ld_rfr = l_frac;
			end
			KIND_FINAL: ld_done = 1'b1;
			default: ;
		endcase
		bump      = {1'b0, ld_rf} + {1'b0, ld_df};
		sum       = {1'b0, total_q} + (TOTAL_W+1)'(bump);
		new_total = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
	end

	// counters move when an input is committed: with its last result load, or alone if it has none
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			prior_q <= '0;
			total_q <= '0;
		end else begin
			if (cmd.commit && last_col && last_row)
				total_q <= '0;
			else if (cmd.load)
				total_q <= new_total;
			if (cmd.commit) begin
				prior_q <= pix_q;
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pixel_col      <= ld_col;
			pixel_row      <= ld_row;
			right_found    <= ld_rf;
			right_frac     <= ld_rfr;
			down_found     <= ld_df;
			down_frac      <= ld_dfr;
			crossing_total <= new_total;
			run_last       <= cmd.run_last;
			frame_done     <= ld_done;
		end
	end

endmodule

// ===== rtl/tecf_ctrl.sv =====
// Controller: sequences memory reads, divider steps and result loads for one pixel.
// Depends on tecf_pkg.
module tecf_ctrl import tecf_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	localparam int STEP_W = $clog2(FRAC_BITS + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RD1  = 5'b00010,
		S_RD2  = 5'b00100,
		S_DIV  = 5'b01000,
		S_EMIT = 5'b10000
	} state_t;

	state_t            state_q, state_d;
	logic [STEP_W-1:0] cnt_q, cnt_d;
	logic [2:0]        pend_q, pend_d;  // {final, left, up} still to send
	logic [2:0]        lowest;

	assign lowest = pend_q & (~pend_q + 3'd1);

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		pend_d   = pend_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_RD1;
				end
			end
			S_RD1: begin
				cmd.cap_up  = 1'b1;
				cmd.rd_next = 1'b1;
				state_d     = S_RD2;
			end
			S_RD2: begin
				cmd.start = 1'b1;
				cnt_d     = '0;
				state_d   = S_DIV;
			end
			S_DIV: begin
				cmd.step = 1'b1;
				cnt_d    = cnt_q + STEP_W'(1);
				if (cnt_q == STEP_W'(FRAC_BITS)) begin
					pend_d  = {status.has_final, status.has_left, status.has_up};
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (pend_q == '0) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end else if (status.slot_free) begin
					cmd.load = 1'b1;
					if (pend_q[0])
						cmd.kind = KIND_UP;
					else if (pend_q[1])
						cmd.kind = KIND_LEFT;
					else
						cmd.kind = KIND_FINAL;
					pend_d       = pend_q & ~lowest;
					cmd.run_last = (pend_d == '0);
					if (pend_d == '0) begin
						cmd.commit = 1'b1;
						state_d    = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pend_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pend_q  <= pend_d;
		end
	end

endmodule

// ===== rtl/tecf_checker.sv =====
// Port-level checks for the threshold edge crossing finder, bound to the top level.
// Depends on tecf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tecf_checker import tecf_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int FRAC_BITS = 8,
	localparam int COL_W = $clog2(MAX_WIDTH)
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [COL_W-1:0]     pixel_col,
	input logic [ROW_W-1:0]     pixel_row,
	input logic                 right_found,
	input logic [FRAC_BITS:0]   right_frac,
	input logic                 down_found,
	input logic [FRAC_BITS:0]   down_frac,
	input logic [TOTAL_W-1:0]   crossing_total,
	input logic                 run_last,
	input logic                 frame_done
);

	// a stalled transaction keeps its position, total and run_last
	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(pixel_col) && $stable(pixel_row) && $stable(crossing_total) && $stable(run_last), "output changed while stalled")

	// the end-of-frame result is the last one of its input and carries no crossing
	`ASSERT_NEVER(a_done_last, clk, arst_n, out_valid && frame_done && !run_last, "frame_done without run_last")
	`ASSERT_NEVER(a_done_empty, clk, arst_n, out_valid && frame_done && (right_found || down_found), "crossing on end-of-frame result")

	// no fraction without a crossing
	`ASSERT_NEVER(a_frac_zero, clk, arst_n, out_valid && ((!right_found && right_frac != '0) || (!down_found && down_frac != '0)), "fraction set without crossing")

endmodule

bind threshold_edge_crossing_finder_top tecf_checker #(
	.MAX_WIDTH(MAX_WIDTH),
	.FRAC_BITS(FRAC_BITS)
) u_checker (.*);
